// ===== rtl/fcsa_pkg.sv =====
// shared types and codes for the frustum culling block
package fcsa_pkg;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_SPHERE = 2'd1,
        REQ_BOX    = 2'd2,
        REQ_NONE   = 2'd3
    } req_type_t;

    localparam int COORD_W = 32;
    localparam int PROD_W  = 64;
    localparam int SUM_W   = 67;

    typedef struct packed {
        logic signed [COORD_W-1:0] a;
        logic signed [COORD_W-1:0] b;
        logic signed [COORD_W-1:0] c;
        logic signed [COORD_W-1:0] d;
    } plane_t;

endpackage

// ===== rtl/fcsa_plane_test.sv =====
// one plane's distance test, three register stages
module fcsa_plane_test (
    input  logic                               aclk,
    input  logic                               adv,
    input  fcsa_pkg::plane_t                   plane,
    input  logic                               is_box,
    input  logic signed [fcsa_pkg::COORD_W-1:0] lo_x,
    input  logic signed [fcsa_pkg::COORD_W-1:0] lo_y,
    input  logic signed [fcsa_pkg::COORD_W-1:0] lo_z,
    input  logic signed [fcsa_pkg::COORD_W-1:0] hi_x,
    input  logic signed [fcsa_pkg::COORD_W-1:0] hi_y,
    input  logic signed [fcsa_pkg::COORD_W-1:0] hi_z,
    output logic                               reject
);
    import fcsa_pkg::*;

    logic signed [COORD_W-1:0] px, py, pz;
    logic signed [COORD_W:0]   extra;
    logic signed [PROD_W-1:0]  pa_reg, pb_reg, pc_reg, pa_next, pb_next, pc_next;
    logic signed [COORD_W:0]   ex_reg;
    logic signed [SUM_W-1:0]   s1_reg, s1_next, s2_reg, s2_next;
    logic signed [PROD_W-1:0]  pc2_reg;
    logic signed [COORD_W:0]   ex2_reg;

    always_comb begin
        px = (is_box && plane.a > 0) ? hi_x : lo_x;
        py = (is_box && plane.b > 0) ? hi_y : lo_y;
        pz = (is_box && plane.c > 0) ? hi_z : lo_z;
        extra = is_box ? {plane.d[COORD_W-1], plane.d}
                       : {plane.d[COORD_W-1], plane.d} + {hi_x[COORD_W-1], hi_x};
        pa_next = plane.a * px;
        pb_next = plane.b * py;
        pc_next = plane.c * pz;
        s1_next = SUM_W'(pa_reg) + SUM_W'(pb_reg);
        s2_next = s1_reg + SUM_W'(pc2_reg) + (SUM_W'(ex2_reg) <<< 16);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pa_reg  <= pa_next;
            pb_reg  <= pb_next;
            pc_reg  <= pc_next;
            ex_reg  <= extra;
            s1_reg  <= s1_next;
            pc2_reg <= pc_reg;
            ex2_reg <= ex_reg;
            s2_reg  <= s2_next;
        end
    end

    assign reject = s2_reg[SUM_W-1];
endmodule

// ===== rtl/frustum_cull_sphere_aabb.sv =====
// top level: plane store and pipelined sphere and box culling
//
// Requests arrive on the s_ channel. A load request writes one plane
// (a, b, c, d) and gives no result; loads to an index at or above
// PLANE_COUNT and request type 3 are dropped. Sphere and box requests
// give one result on the m_ channel: visible and test_kind.
// For a sphere, lo_x/lo_y/lo_z is the center and hi_x the radius.
// All planes are tested in parallel lanes; each lane multiplies in the
// first stage, adds in the next two, and a final stage ors the rejects.
// A request passes these stages in order from acceptance to m_valid; one
// request per cycle is taken unless the receiver stalls. A load takes
// effect for every request accepted after it. Reset clears all planes to
// zero and empties the pipeline. When the receiver stalls, the whole
// pipeline holds; s_ready is low only while the output register is full
// and not being taken, so nothing is lost or repeated.
module frustum_cull_sphere_aabb #(
    parameter int PLANE_COUNT = 6
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_req_type,
    input  logic [2:0]                          s_plane_index,
    input  logic signed [fcsa_pkg::COORD_W-1:0] s_coeff_a,
    input  logic signed [fcsa_pkg::COORD_W-1:0] s_coeff_b,
    input  logic signed [fcsa_pkg::COORD_W-1:0] s_coeff_c,
    input  logic signed [fcsa_pkg::COORD_W-1:0] s_coeff_d,
    input  logic signed [fcsa_pkg::COORD_W-1:0] s_lo_x,
    input  logic signed [fcsa_pkg::COORD_W-1:0] s_lo_y,
    input  logic signed [fcsa_pkg::COORD_W-1:0] s_lo_z,
    input  logic signed [fcsa_pkg::COORD_W-1:0] s_hi_x,
    input  logic signed [fcsa_pkg::COORD_W-1:0] s_hi_y,
    input  logic signed [fcsa_pkg::COORD_W-1:0] s_hi_z,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_visible,
    output logic                                m_test_kind
);
    import fcsa_pkg::*;

    localparam int DEPTH = 3;

    plane_t plane_reg [PLANE_COUNT];
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] kind_reg;
    logic [PLANE_COUNT-1:0] rej;
    logic adv, acc, is_test, is_box;
    logic out_vld_reg, out_vis_reg, out_kind_reg;
    req_type_t rt;

    assign adv     = !out_vld_reg || m_ready;
    assign s_ready = adv;
    assign acc     = s_valid && s_ready;
    assign rt      = req_type_t'(s_req_type);
    assign is_box  = (rt == REQ_BOX);
    assign is_test = (rt == REQ_SPHERE) || (rt == REQ_BOX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PLANE_COUNT; i++) plane_reg[i] <= '0;
        end else if (acc && rt == REQ_LOAD && 32'(s_plane_index) < PLANE_COUNT) begin
            for (int i = 0; i < PLANE_COUNT; i++) begin
                if (32'(s_plane_index) == i) begin
                    plane_reg[i] <= '{s_coeff_a, s_coeff_b, s_coeff_c, s_coeff_d};
                end
            end
        end
    end

    for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_lane
        fcsa_plane_test u_test (
            .aclk   (aclk),
            .adv    (adv),
            .plane  (plane_reg[g]),
            .is_box (is_box),
            .lo_x   (s_lo_x),
            .lo_y   (s_lo_y),
            .lo_z   (s_lo_z),
            .hi_x   (s_hi_x),
            .hi_y   (s_hi_y),
            .hi_z   (s_hi_z),
            .reject (rej[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[DEPTH-2:0], acc && is_test};
            out_vld_reg <= vld_reg[DEPTH-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            kind_reg     <= {kind_reg[DEPTH-2:0], is_box};
            out_vis_reg  <= ~|rej;
            out_kind_reg <= kind_reg[DEPTH-1];
        end
    end

    assign m_valid     = out_vld_reg;
    assign m_visible   = out_vis_reg;
    assign m_test_kind = out_kind_reg;
endmodule
